// ===== sv/qts_pkg.sv =====
// ----------------------------------------------------------------------------
// qts_pkg
// Shared widths, stage counts, types and the saturation helper of the solver.
// ----------------------------------------------------------------------------
package qts_pkg;

    localparam int FLD_W  = 32;
    localparam int DUR_W  = 31;
    localparam int IN_W   = 224;
    localparam int COEF_W = 64;
    localparam int OUT_W  = 6 * COEF_W;
    localparam int NUM_W  = 100;
    localparam int P_W    = 155;
    localparam int D_W    = P_W + 1;
    localparam int M_W    = 164;
    localparam int Q_W    = 64;
    localparam int FE_STG = 11;
    localparam int DV_STG = Q_W + 2;
    localparam int N_STG  = FE_STG + DV_STG + 1;

    localparam logic [COEF_W-1:0] C_MAX = {1'b0, {(COEF_W - 1){1'b1}}};
    localparam logic [COEF_W-1:0] C_MIN = {1'b1, {(COEF_W - 1){1'b0}}};

    typedef struct packed {
        logic signed [FLD_W-1:0] p0;
        logic signed [FLD_W-1:0] v0;
        logic signed [FLD_W-1:0] c0;
        logic                    zero;
    } t_side;

    typedef struct packed {
        logic signed [NUM_W-1:0] n3;
        logic signed [NUM_W-1:0] n4;
        logic signed [NUM_W-1:0] n5;
        logic [92:0]             d3;
        logic [123:0]            d4;
        logic [154:0]            d5;
    } t_front;

    typedef struct packed {
        logic [Q_W-1:0] q;
        logic           ovf;
        logic           neg;
    } t_div_res;

    typedef struct packed {
        logic [COEF_W-1:0] val;
        logic              sat;
    } t_coef;

    function automatic t_coef f_finish(input t_div_res r);
        t_coef c;
        c.sat = 1'b0;
        c.val = r.q;
        if (r.ovf) begin
            c.sat = 1'b1;
            c.val = r.neg ? C_MIN : C_MAX;
        end else if (r.neg) begin
            if (r.q > C_MIN) begin
                c.sat = 1'b1;
                c.val = C_MIN;
            end else begin
                c.val = -r.q;
            end
        end else if (r.q[Q_W-1]) begin
            c.sat = 1'b1;
            c.val = C_MAX;
        end
        return c;
    endfunction

endpackage

// ===== sv/qts_mul.sv =====
// ----------------------------------------------------------------------------
// qts_mul
// Two-stage unsigned multiplier: 32-bit slices of A times a 31-bit B, then sum.
// ----------------------------------------------------------------------------
module qts_mul #(
    parameter int WA = 32
) (
    input  logic           i_clk,
    input  logic [1:0]     i_en,
    input  logic [WA-1:0]  i_a,
    input  logic [30:0]    i_b,
    output logic [WA+30:0] o_p
);
    localparam int NC = (WA + 31) / 32;
    localparam int AW = NC * 32;
    localparam int SW = AW + 31;

    logic [AW-1:0] w_a;
    logic [62:0]   r_pp [NC];
    logic [SW-1:0] n_sum;
    logic [WA+30:0] r_p;

    assign w_a = AW'(i_a);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int k = 0; k < NC; k++) begin
                r_pp[k] <= 63'(w_a[k*32 +: 32]) * 63'(i_b);
            end
        end
    end

    always_comb begin
        n_sum = '0;
        for (int k = 0; k < NC; k++) begin
            n_sum = n_sum + (SW'(r_pp[k]) << (32 * k));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_p <= n_sum[WA+30:0];
        end
    end

    assign o_p = r_p;

endmodule

// ===== sv/qts_front.sv =====
// ----------------------------------------------------------------------------
// qts_front
// Residuals, products with T, the three numerators and the powers of T.
// ----------------------------------------------------------------------------
module qts_front (
    input  logic                           i_clk,
    input  logic [qts_pkg::FE_STG-1:0]     i_en,
    input  logic signed [qts_pkg::FLD_W-1:0] i_start_pos,
    input  logic signed [qts_pkg::FLD_W-1:0] i_start_vel,
    input  logic signed [qts_pkg::FLD_W-1:0] i_start_acc,
    input  logic signed [qts_pkg::FLD_W-1:0] i_end_pos,
    input  logic signed [qts_pkg::FLD_W-1:0] i_end_vel,
    input  logic signed [qts_pkg::FLD_W-1:0] i_end_acc,
    input  logic [qts_pkg::DUR_W-1:0]      i_duration,
    output qts_pkg::t_front                o_front
);
    import qts_pkg::*;

    typedef struct packed {
        logic               v0n;
        logic               c0n;
        logic               x2n;
        logic signed [32:0] dp;
        logic signed [32:0] dv;
    } t_f1;

    typedef struct packed {
        logic               x1n;
        logic               cdn;
        logic               x2n;
        logic signed [63:0] vd;
        logic signed [32:0] dp;
    } t_f4;

    typedef struct packed {
        logic signed [NUM_W-1:0] n3;
        logic signed [NUM_W-1:0] n4;
        logic signed [NUM_W-1:0] n5;
    } t_nums;

    logic [DUR_W-1:0] r_d [1:9];

    logic signed [31:0] r1_v0, r1_c0;
    logic signed [32:0] r1_x2;
    t_f1                r1_f, r2_f, r3_f;
    logic [31:0]        w_v0m, w_c0m;
    logic [32:0]        w_x2m;
    logic [62:0]        w_vdm, w_cdm;
    logic [63:0]        w_x2dm;
    logic [61:0]        w_dd;

    logic               r4_x1n, r4_cdn, r4_x2n;
    logic [62:0]        r4_x1m, r4_cdm;
    logic [63:0]        r4_x2dm;
    logic [61:0]        r4_dd;
    logic signed [63:0] r4_vd;
    logic signed [32:0] r4_dp;
    logic signed [63:0] w_vd, w_cd;
    logic signed [65:0] w_x1;
    t_f4                r5_f, r6_f;

    logic [93:0]        w_x1d, w_cdd;
    logic [94:0]        w_x2dd;
    logic [92:0]        w_d3;

    logic signed [NUM_W-1:0] r7_x0, r7_y1, r7_y2;
    logic [92:0]             r7_d3, r8_d3, r9_d3, r10_d3, r11_d3;
    t_nums                   r8_nm, r9_nm, r10_nm, r11_nm;
    logic [123:0]            w_d4, r10_d4, r11_d4;
    logic [154:0]            w_d5;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_d[1] <= i_duration;
        end
        for (int k = 2; k <= 9; k++) begin
            if (i_en[k-1]) begin
                r_d[k] <= r_d[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_v0   <= i_start_vel;
            r1_c0   <= i_start_acc;
            r1_x2   <= 33'(i_end_acc) - 33'(i_start_acc);
            r1_f.v0n <= i_start_vel[31];
            r1_f.c0n <= i_start_acc[31];
            r1_f.x2n <= (i_end_acc < i_start_acc);
            r1_f.dp <= 33'(i_end_pos) - 33'(i_start_pos);
            r1_f.dv <= 33'(i_end_vel) - 33'(i_start_vel);
        end
    end

    assign w_v0m = r1_v0[31] ? 32'(-r1_v0) : 32'(r1_v0);
    assign w_c0m = r1_c0[31] ? 32'(-r1_c0) : 32'(r1_c0);
    assign w_x2m = r1_x2[32] ? 33'(-r1_x2) : 33'(r1_x2);

    qts_mul #(.WA(32)) u_mul_vd  (.i_clk, .i_en(i_en[2:1]), .i_a(w_v0m), .i_b(r_d[1]),
                                  .o_p(w_vdm));
    qts_mul #(.WA(32)) u_mul_cd  (.i_clk, .i_en(i_en[2:1]), .i_a(w_c0m), .i_b(r_d[1]),
                                  .o_p(w_cdm));
    qts_mul #(.WA(33)) u_mul_x2d (.i_clk, .i_en(i_en[2:1]), .i_a(w_x2m), .i_b(r_d[1]),
                                  .o_p(w_x2dm));
    qts_mul #(.WA(31)) u_mul_dd  (.i_clk, .i_en(i_en[2:1]), .i_a(r_d[1]), .i_b(r_d[1]),
                                  .o_p(w_dd));

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r2_f <= r1_f;
        end
        if (i_en[2]) begin
            r3_f <= r2_f;
        end
    end

    assign w_vd = r3_f.v0n ? -$signed({1'b0, w_vdm}) : $signed({1'b0, w_vdm});
    assign w_cd = r3_f.c0n ? -$signed({1'b0, w_cdm}) : $signed({1'b0, w_cdm});
    assign w_x1 = (66'(r3_f.dv) <<< 16) - 66'(w_cd);

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r4_x1n  <= w_x1[65];
            r4_x1m  <= w_x1[65] ? 63'(-w_x1) : 63'(w_x1);
            r4_cdn  <= r3_f.c0n;
            r4_cdm  <= w_cdm;
            r4_x2n  <= r3_f.x2n;
            r4_x2dm <= w_x2dm;
            r4_dd   <= w_dd;
            r4_vd   <= w_vd;
            r4_dp   <= r3_f.dp;
        end
    end

    qts_mul #(.WA(63)) u_mul_x1d  (.i_clk, .i_en(i_en[5:4]), .i_a(r4_x1m), .i_b(r_d[4]),
                                   .o_p(w_x1d));
    qts_mul #(.WA(63)) u_mul_cdd  (.i_clk, .i_en(i_en[5:4]), .i_a(r4_cdm), .i_b(r_d[4]),
                                   .o_p(w_cdd));
    qts_mul #(.WA(64)) u_mul_x2dd (.i_clk, .i_en(i_en[5:4]), .i_a(r4_x2dm), .i_b(r_d[4]),
                                   .o_p(w_x2dd));
    qts_mul #(.WA(62)) u_mul_d3   (.i_clk, .i_en(i_en[5:4]), .i_a(r4_dd), .i_b(r_d[4]),
                                   .o_p(w_d3));

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r5_f <= '{x1n: r4_x1n, cdn: r4_cdn, x2n: r4_x2n, vd: r4_vd, dp: r4_dp};
        end
        if (i_en[5]) begin
            r6_f <= r5_f;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[6]) begin
            r7_x0 <= (NUM_W'(r6_f.dp) <<< 33) - (NUM_W'(r6_f.vd) <<< 17)
                   - (r6_f.cdn ? -$signed(NUM_W'(w_cdd)) : $signed(NUM_W'(w_cdd)));
            r7_y1 <= r6_f.x1n ? -$signed(NUM_W'(w_x1d)) : $signed(NUM_W'(w_x1d));
            r7_y2 <= r6_f.x2n ? -$signed(NUM_W'(w_x2dd)) : $signed(NUM_W'(w_x2dd));
            r7_d3 <= w_d3;
        end
    end

    qts_mul #(.WA(93))  u_mul_d4 (.i_clk, .i_en(i_en[8:7]), .i_a(r7_d3), .i_b(r_d[7]),
                                  .o_p(w_d4));

    always_ff @(posedge i_clk) begin
        if (i_en[7]) begin
            r8_nm.n3 <= (r7_x0 <<< 3) + (r7_x0 <<< 1) - (r7_y1 <<< 3) + r7_y2;
            r8_nm.n4 <= r7_x0 - (r7_x0 <<< 4) + (r7_y1 <<< 4) - (r7_y1 <<< 1)
                      - (r7_y2 <<< 1);
            r8_nm.n5 <= (r7_x0 <<< 2) + (r7_x0 <<< 1) - (r7_y1 <<< 2) - (r7_y1 <<< 1)
                      + r7_y2;
            r8_d3    <= r7_d3;
        end
        if (i_en[8]) begin
            r9_nm <= r8_nm;
            r9_d3 <= r8_d3;
        end
        if (i_en[9]) begin
            r10_nm <= r9_nm;
            r10_d3 <= r9_d3;
            r10_d4 <= w_d4;
        end
        if (i_en[10]) begin
            r11_nm <= r10_nm;
            r11_d3 <= r10_d3;
            r11_d4 <= r10_d4;
        end
    end

    qts_mul #(.WA(124)) u_mul_d5 (.i_clk, .i_en(i_en[10:9]), .i_a(w_d4), .i_b(r_d[9]),
                                  .o_p(w_d5));

    assign o_front = '{n3: r11_nm.n3, n4: r11_nm.n4, n5: r11_nm.n5,
                       d3: r11_d3, d4: r11_d4, d5: w_d5};

endmodule

// ===== sv/qts_div.sv =====
// ----------------------------------------------------------------------------
// qts_div
// Rounded magnitude divide num * 2^S / (2 p), one quotient bit per stage.
// ----------------------------------------------------------------------------
module qts_div #(
    parameter int S = 32
) (
    input  logic                             i_clk,
    input  logic [qts_pkg::DV_STG-1:0]       i_en,
    input  logic signed [qts_pkg::NUM_W-1:0] i_num,
    input  logic [qts_pkg::P_W-1:0]          i_p,
    output qts_pkg::t_div_res                o_res
);
    import qts_pkg::*;

    logic [NUM_W-1:0] w_mag;
    logic             r_ng0;
    logic [M_W-1:0]   r_m;
    logic [D_W-1:0]   r_d0;

    logic [M_W-1:0]   r_r  [0:Q_W-1];
    logic [D_W-1:0]   r_dv [0:Q_W-1];
    logic [Q_W-1:0]   r_q  [0:Q_W];
    logic             r_ng [0:Q_W];
    logic             r_ov [0:Q_W];

    assign w_mag = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_ng0 <= i_num[NUM_W-1];
            r_m   <= (M_W'(w_mag) << S) + M_W'(i_p);
            r_d0  <= D_W'(i_p) << 1;
        end
        if (i_en[1]) begin
            r_r[0]  <= r_m;
            r_dv[0] <= r_d0;
            r_q[0]  <= '0;
            r_ng[0] <= r_ng0;
            r_ov[0] <= (M_W'(r_m >> Q_W) >= M_W'(r_d0));
        end
    end

    for (genvar j = 0; j < Q_W; j++) begin : g_step
        localparam int I = Q_W - 1 - j;
        localparam logic [M_W-1:0] LO = (M_W'(1) << I) - M_W'(1);
        logic [M_W-1:0] w_hi, w_dx, w_df;
        logic           w_ge;

        assign w_hi = M_W'(r_r[j] >> I);
        assign w_dx = M_W'(r_dv[j]);
        assign w_df = w_hi - w_dx;
        assign w_ge = (w_hi >= w_dx);

        always_ff @(posedge i_clk) begin
            if (i_en[j+2]) begin
                r_q[j+1]  <= w_ge ? (r_q[j] | (Q_W'(1) << I)) : r_q[j];
                r_ng[j+1] <= r_ng[j];
                r_ov[j+1] <= r_ov[j];
            end
        end

        if (j < Q_W - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en[j+2]) begin
                    r_r[j+1]  <= w_ge ? ((w_df << I) | (r_r[j] & LO)) : r_r[j];
                    r_dv[j+1] <= r_dv[j];
                end
            end
        end
    end

    assign o_res = '{q: r_q[Q_W], ovf: r_ov[Q_W], neg: r_ng[Q_W]};

endmodule

// ===== sv/quintic_trajectory_solver.sv =====
// ----------------------------------------------------------------------------
// quintic_trajectory_solver
// Throughput: one trajectory per cycle unless i_m_tready stalls the output;
// every stage holds one item and the 64 one-bit divider stages per
// coefficient set the depth.
// Reset: synchronous active-low reset empties all stages; payload is not reset.
// ----------------------------------------------------------------------------
module quintic_trajectory_solver (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // start_pos, start_vel, start_acc, end_pos, end_vel, end_acc, duration
    input  logic [qts_pkg::IN_W-1:0]    i_s_tdata,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // coef0, coef1, coef2, coef3, coef4, coef5
    output logic [qts_pkg::OUT_W-1:0]   o_m_tdata,
    // error_flag
    output logic [0:0]                  o_m_tuser
);
    import qts_pkg::*;

    logic [N_STG:1]  r_vld;
    logic [N_STG:1]  w_en;
    t_side           r_side [1:N_STG-1];
    t_front          w_front;
    t_div_res        w_r3, w_r4, w_r5;
    t_coef           w_c3, w_c4, w_c5;
    logic [OUT_W-1:0] r_data;
    logic            r_err;
    t_side           w_sd;

    always_comb begin
        w_en[N_STG] = !r_vld[N_STG] || i_m_tready;
        for (int k = N_STG - 1; k >= 1; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[1]) begin
                r_vld[1] <= i_s_tvalid;
            end
            for (int k = 2; k <= N_STG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_side[1] <= '{p0: i_s_tdata[31:0], v0: i_s_tdata[63:32],
                           c0: i_s_tdata[95:64], zero: (i_s_tdata[222:192] == '0)};
        end
        for (int k = 2; k <= N_STG - 1; k++) begin
            if (w_en[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    qts_front u_front (
        .i_clk,
        .i_en        (w_en[FE_STG:1]),
        .i_start_pos (i_s_tdata[31:0]),
        .i_start_vel (i_s_tdata[63:32]),
        .i_start_acc (i_s_tdata[95:64]),
        .i_end_pos   (i_s_tdata[127:96]),
        .i_end_vel   (i_s_tdata[159:128]),
        .i_end_acc   (i_s_tdata[191:160]),
        .i_duration  (i_s_tdata[222:192]),
        .o_front     (w_front)
    );

    qts_div #(.S(32)) u_div3 (
        .i_clk, .i_en(w_en[N_STG-1:FE_STG+1]), .i_num(w_front.n3),
        .i_p(P_W'(w_front.d3)), .o_res(w_r3)
    );
    qts_div #(.S(48)) u_div4 (
        .i_clk, .i_en(w_en[N_STG-1:FE_STG+1]), .i_num(w_front.n4),
        .i_p(P_W'(w_front.d4)), .o_res(w_r4)
    );
    qts_div #(.S(64)) u_div5 (
        .i_clk, .i_en(w_en[N_STG-1:FE_STG+1]), .i_num(w_front.n5),
        .i_p(w_front.d5), .o_res(w_r5)
    );

    assign w_sd = r_side[N_STG-1];
    assign w_c3 = f_finish(w_r3);
    assign w_c4 = f_finish(w_r4);
    assign w_c5 = f_finish(w_r5);

    always_ff @(posedge i_clk) begin
        if (w_en[N_STG]) begin
            r_data[63:0]    <= {{16{w_sd.p0[31]}}, w_sd.p0, 16'b0};
            r_data[127:64]  <= {{16{w_sd.v0[31]}}, w_sd.v0, 16'b0};
            r_data[191:128] <= {{17{w_sd.c0[31]}}, w_sd.c0, 15'b0};
            if (w_sd.zero) begin
                r_data[383:192] <= '0;
                r_err           <= 1'b1;
            end else begin
                r_data[255:192] <= w_c3.val;
                r_data[319:256] <= w_c4.val;
                r_data[383:320] <= w_c5.val;
                r_err           <= w_c3.sat | w_c4.sat | w_c5.sat;
            end
        end
    end

    assign o_s_tready = w_en[1];
    assign o_m_tvalid = r_vld[N_STG];
    assign o_m_tdata  = r_data;
    assign o_m_tuser  = r_err;

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[N_STG] |-> o_s_tready)
        else $error("input not ready while output stage is empty");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_vld[1])
        else $error("accepted transfer did not enter the first stage");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
                                          && $stable(o_m_tuser)))
        else $error("stalled result changed or dropped");

    a_stall_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[1] && !w_en[2]) |-> !o_s_tready)
        else $error("first stage overwritten while blocked");

endmodule

// ===== test/quintic_trajectory_solver_tb.sv =====
// ----------------------------------------------------------------------------
// quintic_trajectory_solver_tb
// Drives start and end states with durations into the solver over its stream
// ports and checks every coefficient and the error flag against a predictor
// that solves the minimum-jerk system in wide integer arithmetic.
// ----------------------------------------------------------------------------
module quintic_trajectory_solver_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qts_pkg::*;

    typedef struct {
        logic [OUT_W-1:0] coefs;
        logic             err;
    } t_traj;

    class traj_scoreboard;
        t_traj pending[$];
        int    mismatches;

        function automatic logic [COEF_W-1:0] round_div(input logic signed [255:0] num,
                                                        input int shift,
                                                        input logic [30:0] dur,
                                                        input int power,
                                                        inout logic sat);
            logic [255:0] mag;
            logic [255:0] den;
            logic [255:0] quo;
            logic         neg;
            neg = num[255];
            mag = neg ? -num : num;
            den = 256'd1;
            for (int i = 0; i < power; i++) den = den * {225'd0, dur};
            mag = (mag << shift) + den;
            quo = mag / (den << 1);
            if (quo[255:64] != 0) begin
                sat = 1'b1;
                return neg ? C_MIN : C_MAX;
            end
            if (neg) begin
                if (quo[63:0] > C_MIN) begin
                    sat = 1'b1;
                    return C_MIN;
                end
                return -quo[63:0];
            end
            if (quo[63]) begin
                sat = 1'b1;
                return C_MAX;
            end
            return quo[63:0];
        endfunction

        function void note_request(input logic [IN_W-1:0] req);
            logic signed [255:0] p0, v0, c0, pe, ve, ce, dd, x0, x1, x2, y1, y2;
            logic [30:0]         dur;
            t_traj               t;
            p0  = $signed(req[31:0]);
            v0  = $signed(req[63:32]);
            c0  = $signed(req[95:64]);
            pe  = $signed(req[127:96]);
            ve  = $signed(req[159:128]);
            ce  = $signed(req[191:160]);
            dur = req[222:192];
            dd  = {225'd0, dur};
            t.err = 1'b0;
            t.coefs[63:0]    = p0[63:0] << 16;
            t.coefs[127:64]  = v0[63:0] << 16;
            t.coefs[191:128] = c0[63:0] << 15;
            if (dur == 0) begin
                t.coefs[383:192] = '0;
                t.err = 1'b1;
            end else begin
                x0 = ((pe - p0) << 33) - ((v0 * dd) << 17) - c0 * dd * dd;
                x1 = ((ve - v0) << 16) - c0 * dd;
                x2 = ce - c0;
                y1 = x1 * dd;
                y2 = x2 * dd * dd;
                t.coefs[255:192] = round_div(10 * x0 - 8 * y1 + y2, 32, dur, 3, t.err);
                t.coefs[319:256] = round_div(-15 * x0 + 14 * y1 - 2 * y2, 48, dur, 4, t.err);
                t.coefs[383:320] = round_div(6 * x0 - 6 * y1 + y2, 64, dur, 5, t.err);
            end
            pending.push_back(t);
        endfunction

        function void check_result(input logic [OUT_W-1:0] coefs, input logic err);
            t_traj t;
            bit    bad;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transfer %h", coefs);
                return;
            end
            t = pending.pop_front();
            bad = 0;
            for (int i = 0; i < 6; i++) begin
                if (coefs[i*64 +: 64] !== t.coefs[i*64 +: 64]) begin
                    bad = 1;
                    if (mismatches < 10)
                        $display("coef%0d expected %h got %h", i, t.coefs[i*64 +: 64],
                                 coefs[i*64 +: 64]);
                end
            end
            if (err !== t.err) begin
                bad = 1;
                if (mismatches < 10) $display("error flag expected %b got %b", t.err, err);
            end
            if (bad) mismatches++;
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_s_tvalid;
    logic               o_s_tready;
    logic [IN_W-1:0]    i_s_tdata;
    logic               o_m_tvalid;
    logic               i_m_tready;
    logic [OUT_W-1:0]   o_m_tdata;
    logic [0:0]         o_m_tuser;

    traj_scoreboard sb = new();
    int             burst_left = 0;

    quintic_trajectory_solver uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] pick_field();
        case ($urandom_range(0, 9))
            0:       return 32'h7fffffff;
            1:       return 32'h80000000;
            2:       return 32'd0;
            3, 4:    return $urandom();
            default: return 32'($urandom_range(0, 20'hfffff)) - 32'h80000;
        endcase
    endfunction

    function automatic logic [30:0] pick_duration();
        case ($urandom_range(0, 19))
            0:       return 31'd0;
            1, 2:    return 31'($urandom());
            3:       return 31'($urandom_range(1, 255));
            4:       return 31'h7fffffff;
            default: return 31'($urandom_range(31'h4000, 31'h140000));
        endcase
    endfunction

    function automatic logic [IN_W-1:0] pack_req(input logic [31:0] p0, v0, c0, pe, ve, ce,
                                                 input logic [30:0] dur);
        return {1'b0, dur, ce, ve, pe, c0, v0, p0};
    endfunction

    task automatic send_request(input logic [IN_W-1:0] req);
        if (burst_left == 0) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 40);
        end else begin
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= req;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_request(req);
        burst_left--;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata, o_m_tuser[0]);
    end

    initial begin
        i_m_tready = 1'b0;
        @(posedge i_rst_n);
        repeat (300) begin
            @(negedge i_clk);
            i_m_tready <= 1'b1;
        end
        @(negedge i_clk);
        i_m_tready <= 1'b0;
        repeat (400) @(negedge i_clk);
        forever begin
            int mode;
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(10, 80)) begin
                @(negedge i_clk);
                case (mode)
                    0:       i_m_tready <= 1'b1;
                    1:       i_m_tready <= ($urandom_range(0, 3) != 0);
                    default: i_m_tready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    initial begin
        #2ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_request(pack_req(0, 0, 0, 0, 0, 0, 31'h10000));
        send_request(pack_req(0, 0, 0, 32'h000a0000, 0, 0, 31'h10000));
        send_request(pack_req(32'h00010000, 32'h00020000, 32'hffff0000, 32'h00050000,
                              32'hfffe0000, 32'h00030000, 31'h00028000));
        send_request(pack_req(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                              32'h80000000, 32'h80000000, 31'd1));
        send_request(pack_req(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
                              32'h7fffffff, 32'h7fffffff, 31'd1));
        send_request(pack_req(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                              32'h7fffffff, 32'h80000000, 31'h7fffffff));
        send_request(pack_req(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                              32'h80000000, 32'h7fffffff, 31'h7fffffff));
        send_request(pack_req(32'h12345678, 32'h9abcdef0, 32'h0fedcba9, 32'h87654321,
                              32'h13579bdf, 32'h2468ace0, 31'd0));
        send_request(pack_req(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                              32'hffffffff, 32'hffffffff, 31'd0));
        send_request(pack_req(0, 0, 0, 32'h00000001, 0, 0, 31'h7fffffff));
        send_request(pack_req(0, 0, 0, 32'h00000001, 0, 0, 31'd3));
        send_request(pack_req(0, 0, 0, 0, 32'h00010000, 0, 31'h00008000));
        send_request(pack_req(0, 0, 0, 0, 0, 32'h00010000, 31'h00001000));
        send_request(pack_req(0, 0, 0, 32'hffffffff, 0, 0, 31'h00030000));
        send_request(pack_req(32'h00100000, 0, 0, 32'h00100000, 0, 0, 31'h00100000));
        send_request(pack_req(0, 32'h00010000, 0, 32'h00010000, 32'h00010000, 0,
                              31'h00010000));

        repeat (1250) begin
            send_request(pack_req(pick_field(), pick_field(), pick_field(), pick_field(),
                                  pick_field(), pick_field(), pick_duration()));
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
